### design/ugbp_pkg.sv
// Shared types and constants of the uniform grid broad phase.
package ugbp_pkg;

  localparam int unsigned MAX_CELLS_DEF = 256;
  localparam int unsigned SLOTS_DEF     = 8;
  localparam int unsigned ID_BITS_DEF   = 6;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned DIV_W     = 16;
  localparam logic [6:0]  MAX_OBJ   = 7'd64;

  localparam logic signed [15:0] WL_RST = 16'sd0;
  localparam logic signed [15:0] WT_RST = 16'sd0;
  localparam logic [14:0]        WW_RST = 15'd4096;
  localparam logic [14:0]        WH_RST = 15'd4096;
  localparam logic [14:0]        CS_RST = 15'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_LEFT   = 3'd0,
    CFG_WORLD_TOP    = 3'd1,
    CFG_WORLD_WIDTH  = 3'd2,
    CFG_WORLD_HEIGHT = 3'd3,
    CFG_CELL_SIZE    = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_RETRIEVE = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_FULL    = 3'd3,
    ST_BIG     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_e;

  typedef struct packed {
    logic    latch;
    logic    clr_step;
    logic    div_start;
    logic    div_store;
    logic    prod_ld;
    logic    walk_init;
    logic    rd;
    logic    wr;
    logic    wr_id;
    logic    slot_next;
    logic    slot_clr;
    logic    cell_next;
    logic    seen_set;
    logic    bit_next;
    logic    full_set;
    logic    emit;
    logic    emit_id;
    status_e emit_st;
    cnt_e    cnt_op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic clr_done;
    logic div_done;
    logic div_rows;
    logic div_last;
    logic grid_bad;
    logic outside;
    logic slot_last;
    logic cell_last;
    logic rd_valid;
    logic rd_match;
    logic full;
    logic seen_empty;
    logic bit_set;
    logic bit_is_last;
    logic out_free;
  } dp_sts_t;

endpackage

### design/ugbp_ram.sv
// Generic single-port RAM with registered read.
module ugbp_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

### design/ugbp_div.sv
// Restoring divider, one quotient bit per cycle.
module ugbp_div #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;

  assign sh   = {rem_q, quo_q[W-1]};
  assign ge   = sh >= {1'b0, divisor_i};
  assign diff = sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### design/ugbp_dp.sv
// Datapath: config, grid math, cell walk, slot memory, ID bitmap, output register.
module ugbp_dp import ugbp_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]           command_i,
  input  logic [5:0]           collider_id_i,
  input  logic signed [15:0]   box_left_i,
  input  logic signed [15:0]   box_top_i,
  input  logic [14:0]          box_width_i,
  input  logic [14:0]          box_height_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic [5:0]           found_id_o,
  output logic                 id_valid_o,
  output logic                 last_o,
  output logic [6:0]           object_total_o,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o
);

  localparam int unsigned NID    = 1 << ID_BITS;
  localparam int unsigned DEPTH  = MAX_CELLS * SLOTS;
  localparam int unsigned CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] DIV_COLS = 3'd0;
  localparam logic [2:0] DIV_ROWS = 3'd1;
  localparam logic [2:0] DIV_X0   = 3'd2;
  localparam logic [2:0] DIV_Y0   = 3'd3;
  localparam logic [2:0] DIV_X1   = 3'd4;
  localparam logic [2:0] DIV_Y1   = 3'd5;

  logic signed [15:0] wl_q, wt_q;
  logic [14:0]        ww_q, wh_q, cs_q;

  cmd_e               cmd_q;
  logic [ID_BITS-1:0] id_q;
  logic signed [15:0] bl_q, bt_q;
  logic [14:0]        bw_q, bh_q;

  logic [2:0]         div_idx_q;
  logic [DIV_W-1:0]   cols_q, rows_q, x0_q, y0_q, x1_q, y1_q;
  logic [31:0]        prod_q;

  logic [CELL_W-1:0]  x_q, y_q, cell_q, row_cell_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic [NID-1:0]     seen_q;
  logic [ID_BITS-1:0] bit_q;
  logic               full_q;
  logic [6:0]         cnt_q, cnt_d;

  logic               out_valid_q;
  status_e            status_q;
  logic [5:0]         found_id_q;
  logic               id_valid_q;
  logic               last_q;
  logic [6:0]         total_q;

  // cfg
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RST;
      wt_q <= WT_RST;
      ww_q <= WW_RST;
      wh_q <= WH_RST;
      cs_q <= CS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORLD_LEFT:   wl_q <= cfg_wdata_i;
        CFG_WORLD_TOP:    wt_q <= cfg_wdata_i;
        CFG_WORLD_WIDTH:  ww_q <= cfg_wdata_i[14:0];
        CFG_WORLD_HEIGHT: wh_q <= cfg_wdata_i[14:0];
        CFG_CELL_SIZE:    cs_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= collider_id_i[ID_BITS-1:0];
      bl_q  <= box_left_i;
      bt_q  <= box_top_i;
      bw_q  <= box_width_i;
      bh_q  <= box_height_i;
    end
  end

  // world bounds
  logic signed [17:0] bx_end, by_end, wx_end, wy_end;
  logic [16:0]        ox_full, oy_full;
  logic [DIV_W-1:0]   ox, oy, ox_end, oy_end;

  assign bx_end  = {{2{bl_q[15]}}, bl_q} + {3'b0, bw_q};
  assign by_end  = {{2{bt_q[15]}}, bt_q} + {3'b0, bh_q};
  assign wx_end  = {{2{wl_q[15]}}, wl_q} + {3'b0, ww_q};
  assign wy_end  = {{2{wt_q[15]}}, wt_q} + {3'b0, wh_q};
  assign ox_full = {bl_q[15], bl_q} - {wl_q[15], wl_q};
  assign oy_full = {bt_q[15], bt_q} - {wt_q[15], wt_q};
  assign ox      = ox_full[15:0];
  assign oy      = oy_full[15:0];
  assign ox_end  = ox + {1'b0, bw_q};
  assign oy_end  = oy + {1'b0, bh_q};

  // divisions
  logic [DIV_W-1:0] dividend, quo, cm1, rm1;
  logic             div_done;

  always_comb begin
    case (div_idx_q)
      DIV_COLS: dividend = {1'b0, ww_q} + {1'b0, cs_q} - 16'd1;
      DIV_ROWS: dividend = {1'b0, wh_q} + {1'b0, cs_q} - 16'd1;
      DIV_X0:   dividend = ox;
      DIV_Y0:   dividend = oy;
      DIV_X1:   dividend = ox_end;
      default:  dividend = oy_end;
    endcase
  end

  ugbp_div #(.W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  ({1'b0, cs_q}),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign cm1 = cols_q - 1'b1;
  assign rm1 = rows_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_idx_q <= DIV_COLS;
    end else if (cmd_i.latch) begin
      div_idx_q <= DIV_COLS;
    end else if (cmd_i.div_store) begin
      div_idx_q <= div_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (div_idx_q)
        DIV_COLS: cols_q <= quo;
        DIV_ROWS: rows_q <= quo;
        DIV_X0:   x0_q   <= (quo > cm1) ? cm1 : quo;
        DIV_Y0:   y0_q   <= (quo > rm1) ? rm1 : quo;
        DIV_X1:   x1_q   <= (quo > cm1) ? cm1 : quo;
        default:  y1_q   <= (quo > rm1) ? rm1 : quo;
      endcase
    end
    if (cmd_i.prod_ld) begin
      prod_q <= cols_q * rows_q;
    end
  end

  // cell walk
  logic [31:0]       base_full;
  logic [ADDR_W-1:0] addr, ram_addr;
  logic              cell_last;

  assign base_full = y0_q * cols_q + {16'b0, x0_q};
  assign cell_last = (x_q == x1_q[CELL_W-1:0]) && (y_q == y1_q[CELL_W-1:0]);
  assign addr      = ADDR_W'(cell_q) * ADDR_W'(SLOTS) + ADDR_W'(slot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      x_q        <= x0_q[CELL_W-1:0];
      y_q        <= y0_q[CELL_W-1:0];
      cell_q     <= base_full[CELL_W-1:0];
      row_cell_q <= base_full[CELL_W-1:0];
      slot_q     <= '0;
      bit_q      <= '0;
    end else begin
      if (cmd_i.cell_next) begin
        slot_q <= '0;
        if (x_q == x1_q[CELL_W-1:0]) begin
          x_q        <= x0_q[CELL_W-1:0];
          y_q        <= y_q + 1'b1;
          row_cell_q <= row_cell_q + cols_q[CELL_W-1:0];
          cell_q     <= row_cell_q + cols_q[CELL_W-1:0];
        end else begin
          x_q    <= x_q + 1'b1;
          cell_q <= cell_q + 1'b1;
        end
      end else if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end else if (cmd_i.slot_next) begin
        slot_q <= slot_q + 1'b1;
      end
      if (cmd_i.bit_next) begin
        bit_q <= bit_q + 1'b1;
      end
    end
  end

  // slot memory
  logic [ID_BITS:0] rdata, wdata;
  logic             rd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.latch) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign ram_addr = cmd_i.clr_step ? clr_addr_q : addr;
  assign wdata    = (cmd_i.wr && cmd_i.wr_id) ? {1'b1, id_q} : '0;

  ugbp_ram #(.WIDTH(ID_BITS + 1), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr | cmd_i.clr_step),
    .re_i    (cmd_i.rd),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign rd_valid = rdata[ID_BITS];

  // ID bitmap and flags
  logic [NID-1:0] bit_mask;
  assign bit_mask = NID'(1) << bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      seen_q <= '0;
      full_q <= 1'b0;
    end else begin
      if (cmd_i.seen_set && rd_valid) begin
        seen_q[rdata[ID_BITS-1:0]] <= 1'b1;
      end else if (cmd_i.emit && cmd_i.emit_id) begin
        seen_q <= seen_q & ~bit_mask;
      end
      if (cmd_i.full_set) begin
        full_q <= 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = (cnt_q < MAX_OBJ) ? cnt_q + 1'b1 : cnt_q;
      CNT_DEC: cnt_d = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= cmd_i.emit_st;
      found_id_q <= cmd_i.emit_id ? 6'(bit_q) : '0;
      id_valid_q <= cmd_i.emit_id;
      last_q     <= cmd_i.emit_id ? ((seen_q & ~bit_mask) == '0) : 1'b1;
      total_q    <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_id_o     = found_id_q;
  assign id_valid_o     = id_valid_q;
  assign last_o         = last_q;
  assign object_total_o = total_q;

  // status
  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.clr_done    = clr_addr_q == ADDR_W'(DEPTH - 1);
    sts_o.div_done    = div_done;
    sts_o.div_rows    = div_idx_q == DIV_ROWS;
    sts_o.div_last    = div_idx_q == DIV_Y1;
    sts_o.grid_bad    = (cs_q == '0) || (prod_q > 32'(MAX_CELLS));
    sts_o.outside     = (cols_q == '0) || (rows_q == '0) || (bl_q < wl_q) || (bt_q < wt_q) ||
                        (bx_end > wx_end) || (by_end > wy_end);
    sts_o.slot_last   = slot_q == SLOT_W'(SLOTS - 1);
    sts_o.cell_last   = cell_last;
    sts_o.rd_valid    = rd_valid;
    sts_o.rd_match    = rd_valid && (rdata[ID_BITS-1:0] == id_q);
    sts_o.full        = full_q;
    sts_o.seen_empty  = seen_q == '0;
    sts_o.bit_set     = seen_q[bit_q];
    sts_o.bit_is_last = (seen_q & ~bit_mask) == '0;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule

### design/ugbp_ctrl.sv
// Command sequencer for the broad phase.
module ugbp_ctrl import ugbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [17:0] {
    S_INIT     = 18'h00001,
    S_IDLE     = 18'h00002,
    S_CLR      = 18'h00004,
    S_DIV_GO   = 18'h00008,
    S_DIV_WAIT = 18'h00010,
    S_MUL      = 18'h00020,
    S_CHK      = 18'h00040,
    S_BASE     = 18'h00080,
    S_DUP_RD   = 18'h00100,
    S_DUP_CHK  = 18'h00200,
    S_INS_RD   = 18'h00400,
    S_INS_CHK  = 18'h00800,
    S_DEL_RD   = 18'h01000,
    S_DEL_CHK  = 18'h02000,
    S_RET_RD   = 18'h04000,
    S_RET_CHK  = 18'h08000,
    S_SCAN     = 18'h10000,
    S_FIN      = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DIV_GO;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_FIN;
      end
      S_DIV_GO: begin
        if (sts_i.cmd == CMD_CLEAR) begin
          state_d = S_CLR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sts_i.div_rows) state_d = S_MUL;
          else if (sts_i.div_last) state_d = S_BASE;
          else state_d = S_DIV_GO;
        end
      end
      S_MUL: begin
        cmd_o.prod_ld = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        if (sts_i.grid_bad || sts_i.outside) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_st = sts_i.grid_bad ? ST_BIG : ST_OUTSIDE;
            state_d       = S_IDLE;
          end
        end else begin
          state_d = S_DIV_GO;
        end
      end
      S_BASE: begin
        cmd_o.walk_init = 1'b1;
        case (sts_i.cmd)
          CMD_INSERT: state_d = S_DUP_RD;
          CMD_DELETE: state_d = S_DEL_RD;
          default:    state_d = S_RET_RD;
        endcase
      end
      S_DUP_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DUP_CHK;
      end
      S_DUP_CHK: begin
        if (sts_i.rd_match) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_st = ST_DUP;
            state_d       = S_IDLE;
          end
        end else if (sts_i.slot_last) begin
          cmd_o.slot_clr = 1'b1;
          state_d        = S_INS_RD;
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_DUP_RD;
        end
      end
      S_INS_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (!sts_i.rd_valid || sts_i.slot_last) begin
          if (!sts_i.rd_valid) begin
            cmd_o.wr    = 1'b1;
            cmd_o.wr_id = 1'b1;
          end else begin
            cmd_o.full_set = 1'b1;
          end
          if (sts_i.cell_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.cell_next = 1'b1;
            state_d         = S_INS_RD;
          end
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_INS_RD;
        end
      end
      S_DEL_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        cmd_o.wr = sts_i.rd_match;
        if (!sts_i.slot_last) begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_DEL_RD;
        end else if (sts_i.cell_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d         = S_DEL_RD;
        end
      end
      S_RET_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RET_CHK;
      end
      S_RET_CHK: begin
        cmd_o.seen_set = 1'b1;
        if (!sts_i.slot_last) begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_RET_RD;
        end else if (sts_i.cell_last) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d         = S_RET_RD;
        end
      end
      S_SCAN: begin
        if (sts_i.seen_empty) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (sts_i.bit_set) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_id = 1'b1;
            if (sts_i.bit_is_last) state_d = S_IDLE;
            else cmd_o.bit_next = 1'b1;
          end
        end else begin
          cmd_o.bit_next = 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          case (sts_i.cmd)
            CMD_INSERT: begin
              cmd_o.cnt_op  = CNT_INC;
              cmd_o.emit_st = sts_i.full ? ST_FULL : ST_OK;
            end
            CMD_DELETE: cmd_o.cnt_op = CNT_DEC;
            CMD_CLEAR:  cmd_o.cnt_op = CNT_CLR;
            default:    cmd_o.cnt_op = CNT_HOLD;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/uniform_grid_broadphase_core.sv
// Uniform grid broad phase: insert, delete, retrieve and clear of collider IDs in grid cells.
// One command is taken at a time and gives its results before the next is accepted. After
// reset the slot memory is swept clean, one entry a cycle, over all MAX_CELLS*SLOTS entries
// (2048 by default), with no command taken; a clear runs the same sweep. Other commands run
// up to six serial divisions on the shared divider, then walk the covered cells, a read and a
// check state per slot of the single-port slot memory (an insert adds a duplicate scan of its
// first cell and stops in a cell at the first free slot); a retrieve then scans the ID bitmap
// one bit a cycle, holding at a set bit while the output stalls, one result per set bit.
module uniform_grid_broadphase_core import ugbp_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [5:0]           collider_id_i,
  input  logic signed [15:0]   box_left_i,
  input  logic signed [15:0]   box_top_i,
  input  logic [14:0]          box_width_i,
  input  logic [14:0]          box_height_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [5:0]           found_id_o,
  output logic                 id_valid_o,
  output logic                 last_o,
  output logic [6:0]           object_total_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ugbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ugbp_dp #(
    .MAX_CELLS (MAX_CELLS),
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .collider_id_i  (collider_id_i),
    .box_left_i     (box_left_i),
    .box_top_i      (box_top_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .found_id_o     (found_id_o),
    .id_valid_o     (id_valid_o),
    .last_o         (last_o),
    .object_total_o (object_total_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
